// ===== rtl/text_to_page_framebuffer_top_macros.svh =====
// ----------------------------------------------------------------------------
// text_to_page_framebuffer_top_macros
// assertion shorthands used by the frame buffer datapath
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_PAGE_FRAMEBUFFER_TOP_MACROS_SVH
`define TEXT_TO_PAGE_FRAMEBUFFER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TTPF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TTPF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ttpf_pkg
// shared types and constants of the page frame buffer with character generator
// ----------------------------------------------------------------------------
package ttpf_pkg;

  // default geometry
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int GLYPH_WIDTH_DEF   = 5;
  localparam int GLYPH_HEIGHT_DEF  = 7;
  localparam int GLYPH_GAP_DEF     = 1;
  localparam int GLYPH_COUNT_DEF   = 128;

  // stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;

  // operation codes carried in in_tuser
  typedef enum logic [2:0] {
    OP_LOAD_GLYPH = 3'd0,
    OP_START_TEXT = 3'd1,
    OP_PUT_CHAR   = 3'd2,
    OP_SET_PIXEL  = 3'd3,
    OP_CLEAR_FROM = 3'd4,
    OP_READ_BYTE  = 3'd5
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic glyph_wr;
    logic glyph_rd;
    logic cursor_set;
    logic cursor_wrap;
    logic cursor_adv;
    logic col_clr;
    logic col_inc;
    logic fb_rd;
    logic page_sel;
    logic byte_rd;
    logic clr_init;
    logic clr_wr;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic newline;
    logic col_last;
    logic clr_done;
    logic out_full;
  } dp_sts_t;

endpackage

// ===== rtl/text_to_page_framebuffer_top.sv =====
// put_char draws one glyph at the cursor, a newline only moves the cursor;
// the draw loop is two frame store read-modify-writes per glyph column.
// read_byte waits in dispatch while an untaken result still blocks the output.
// clear_from zeroes from its start to the end of the store, one byte per cycle.
// after reset a clearing pass zeroes the whole frame store with in_tready low.
// ----------------------------------------------------------------------------
// text_to_page_framebuffer_top
// page organized monochrome frame buffer with a loadable 5x7 character generator
// ----------------------------------------------------------------------------
module text_to_page_framebuffer_top #(
  parameter int SCREEN_WIDTH  = ttpf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttpf_pkg::SCREEN_HEIGHT_DEF,
  parameter int GLYPH_WIDTH   = ttpf_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT  = ttpf_pkg::GLYPH_HEIGHT_DEF,
  parameter int GLYPH_GAP     = ttpf_pkg::GLYPH_GAP_DEF,
  parameter int GLYPH_COUNT   = ttpf_pkg::GLYPH_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x[8:0], pos_y[19:9], char_code[26:20], glyph_column[29:27],
  // glyph_bits[37:30], ink_on[38], byte_index[48:39], zero fill above
  input  logic [ttpf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op[2:0]
  input  logic [ttpf_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_data[7:0]
  output logic [ttpf_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  ttpf_pkg::dp_cmd_t cmd;
  ttpf_pkg::dp_sts_t sts;

  // sequencer
  ttpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores, cursor and result register
  ttpf_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GLYPH_WIDTH   (GLYPH_WIDTH),
    .GLYPH_HEIGHT  (GLYPH_HEIGHT),
    .GLYPH_GAP     (GLYPH_GAP),
    .GLYPH_COUNT   (GLYPH_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/ttpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttpf_ctrl
// sequencer that steps the datapath through each operation
// ----------------------------------------------------------------------------
module ttpf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ttpf_pkg::dp_sts_t sts,
  output ttpf_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_GLYPH,
    S_DRAW_P0,
    S_DRAW_P1,
    S_READ_OUT
  } state_t;

  state_t state_r, state_nxt;

  // accept only between operations
  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_wr = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          ttpf_pkg::OP_LOAD_GLYPH: begin
            cmd.glyph_wr = 1'b1;
            state_nxt    = S_IDLE;
          end
          ttpf_pkg::OP_START_TEXT: begin
            cmd.cursor_set = 1'b1;
            state_nxt      = S_IDLE;
          end
          ttpf_pkg::OP_PUT_CHAR: begin
            cmd.cursor_wrap = 1'b1;
            state_nxt       = sts.newline ? S_IDLE : S_GLYPH;
          end
          ttpf_pkg::OP_SET_PIXEL: begin
            // the write back follows on its own in the next cycle
            cmd.fb_rd = 1'b1;
            state_nxt = S_IDLE;
          end
          ttpf_pkg::OP_CLEAR_FROM: begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLEAR;
          end
          ttpf_pkg::OP_READ_BYTE: begin
            if (!sts.out_full) begin
              cmd.byte_rd = 1'b1;
              state_nxt   = S_READ_OUT;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_GLYPH: begin
        cmd.glyph_rd = 1'b1;
        cmd.col_clr  = 1'b1;
        state_nxt    = S_DRAW_P0;
      end
      S_DRAW_P0: begin
        cmd.fb_rd = 1'b1;
        state_nxt = S_DRAW_P1;
      end
      S_DRAW_P1: begin
        cmd.fb_rd    = 1'b1;
        cmd.page_sel = 1'b1;
        if (sts.col_last) begin
          cmd.cursor_adv = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.col_inc  = 1'b1;
          cmd.glyph_rd = 1'b1;
          state_nxt    = S_DRAW_P0;
        end
      end
      S_READ_OUT: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
    endcase
  end

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/ttpf_dp.sv =====
// ----------------------------------------------------------------------------
// ttpf_dp
// item registers, cursor, glyph store, frame store and read-modify-write path
// ----------------------------------------------------------------------------
`include "text_to_page_framebuffer_top_macros.svh"

module ttpf_dp #(
  parameter int SCREEN_WIDTH  = ttpf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttpf_pkg::SCREEN_HEIGHT_DEF,
  parameter int GLYPH_WIDTH   = ttpf_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT  = ttpf_pkg::GLYPH_HEIGHT_DEF,
  parameter int GLYPH_GAP     = ttpf_pkg::GLYPH_GAP_DEF,
  parameter int GLYPH_COUNT   = ttpf_pkg::GLYPH_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ttpf_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [ttpf_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  ttpf_pkg::dp_cmd_t                  cmd,
  output ttpf_pkg::dp_sts_t                  sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ttpf_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int FB_BYTES    = PAGES * SCREEN_WIDTH;
  localparam int FB_AW       = $clog2(FB_BYTES);
  localparam int CLR_W       = $clog2(FB_BYTES + 1);
  localparam int GLYPH_BYTES = GLYPH_COUNT * GLYPH_WIDTH;
  localparam int GA_W        = (GLYPH_BYTES > 1) ? $clog2(GLYPH_BYTES) : 1;
  localparam int CC_W        = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

  localparam logic [7:0]              HMASK     = 8'((1 << GLYPH_HEIGHT) - 1);
  localparam logic [7:0]              LAST_MASK = ((SCREEN_HEIGHT % 8) == 0) ? 8'hFF :
                                                  8'((1 << (SCREEN_HEIGHT % 8)) - 1);
  localparam logic signed [9:0]       WIDTH_S   = 10'(SCREEN_WIDTH);
  localparam logic signed [9:0]       WRAP_LIM  = 10'(SCREEN_WIDTH - GLYPH_WIDTH);
  localparam logic signed [8:0]       PAGES_S   = 9'(PAGES);
  localparam logic signed [11:0]      ROW_STEP  = 12'(GLYPH_HEIGHT + 1);
  localparam logic signed [9:0]       COL_STEP  = 10'(GLYPH_WIDTH + GLYPH_GAP);
  localparam logic signed [11:0]      ROW_LIM   = 12'sd1023;
  localparam logic signed [9:0]       COL_LIM   = 10'sd255;
  localparam logic signed [10:0]      ROW_MAX   = 11'sd1023;
  localparam logic signed [8:0]       COL_MAX   = 9'sd255;
  localparam logic [6:0]              NEWLINE   = 7'd10;
  localparam logic [8:0]              GCOUNT    = 9'(GLYPH_COUNT);
  localparam logic [3:0]              GWIDTH    = 4'(GLYPH_WIDTH);
  localparam logic [CLR_W-1:0]        FB_END    = CLR_W'(FB_BYTES);
  localparam logic [12:0]             FB_SIZE   = 13'(FB_BYTES);
  localparam logic signed [20:0]      W_S21     = 21'(SCREEN_WIDTH);
  localparam logic signed [20:0]      FB_S21    = 21'(FB_BYTES);
  localparam logic [CC_W-1:0]         COL_LAST  = CC_W'(GLYPH_WIDTH - 1);
  localparam logic [FB_AW-1:0]        W_A       = FB_AW'(SCREEN_WIDTH);
  localparam logic [GA_W-1:0]         GW_A      = GA_W'(GLYPH_WIDTH);

  // captured item
  ttpf_pkg::op_t      op_r;
  logic signed [8:0]  px_r;
  logic signed [10:0] py_r;
  logic [6:0]         code_r;
  logic [2:0]         gcol_r;
  logic [7:0]         gbits_r;
  logic               ink_r;
  logic [9:0]         bidx_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= ttpf_pkg::op_t'(in_tuser[2:0]);
      px_r    <= in_tdata[8:0];
      py_r    <= in_tdata[19:9];
      code_r  <= in_tdata[26:20];
      gcol_r  <= in_tdata[29:27];
      gbits_r <= in_tdata[37:30];
      ink_r   <= in_tdata[38];
      bidx_r  <= in_tdata[48:39];
    end
  end

  // text cursor
  logic signed [8:0]  cur_col_r, cur_col_nxt;
  logic signed [10:0] cur_row_r, cur_row_nxt;
  logic               wrap_need;
  logic signed [11:0] row_inc;
  logic signed [9:0]  col_inc;

  always_comb begin
    wrap_need   = (code_r == NEWLINE) || ($signed({cur_col_r[8], cur_col_r}) > WRAP_LIM);
    row_inc     = $signed({cur_row_r[10], cur_row_r}) + ROW_STEP;
    col_inc     = $signed({cur_col_r[8], cur_col_r}) + COL_STEP;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (cmd.cursor_set) begin
      cur_col_nxt = px_r;
      cur_row_nxt = py_r;
    end else if (cmd.cursor_wrap && wrap_need) begin
      cur_col_nxt = '0;
      cur_row_nxt = (row_inc > ROW_LIM) ? ROW_MAX : row_inc[10:0];
    end else if (cmd.cursor_adv) begin
      cur_col_nxt = (col_inc > COL_LIM) ? COL_MAX : col_inc[8:0];
    end
  end

  // glyph column counter
  logic [CC_W-1:0] col_r, col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (cmd.col_clr) begin
      col_nxt = '0;
    end else if (cmd.col_inc) begin
      col_nxt = col_r + CC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      col_r     <= '0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      col_r     <= col_nxt;
    end
  end

  // glyph store, read ahead one column
  logic [7:0]      glyph_mem [GLYPH_BYTES];
  logic [7:0]      glyph_rdata_r;
  logic            glyph_we;
  logic            glyph_blank;
  logic [GA_W-1:0] gw_addr;
  logic [GA_W-1:0] gr_addr;

  always_comb begin
    glyph_we    = cmd.glyph_wr && ({2'b00, code_r} < GCOUNT) && ({1'b0, gcol_r} < GWIDTH);
    glyph_blank = !({2'b00, code_r} < GCOUNT);
    gw_addr     = GA_W'(code_r) * GW_A + GA_W'(gcol_r);
    gr_addr     = GA_W'(code_r) * GW_A + GA_W'(col_nxt);
  end

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[gw_addr] <= gbits_r;
    end
    if (cmd.glyph_rd) begin
      glyph_rdata_r <= glyph_mem[gr_addr];
    end
  end

  // draw target: one byte of the current column on page y/8 or the one below
  logic               is_pix;
  logic signed [9:0]  x_s;
  logic signed [10:0] y_s;
  logic signed [8:0]  page_s;
  logic [2:0]         off;
  logic [7:0]         col_bits;
  logic [7:0]         hmask8;
  logic [7:0]         ink_bits;
  logic [15:0]        m16;
  logic [15:0]        v16;
  logic               col_ok;
  logic               page_ok;
  logic [7:0]         pvalid;
  logic [7:0]         tgt_mask;
  logic [7:0]         tgt_val;
  logic [FB_AW-1:0]   tgt_addr;

  always_comb begin
    is_pix   = (op_r == ttpf_pkg::OP_SET_PIXEL);
    x_s      = is_pix ? $signed({px_r[8], px_r}) :
               ($signed({cur_col_r[8], cur_col_r}) + $signed(10'(col_r)));
    y_s      = is_pix ? py_r : cur_row_r;
    page_s   = $signed({y_s[10], y_s[10:3]}) + $signed({8'b0, cmd.page_sel});
    off      = y_s[2:0];
    col_bits = is_pix ? 8'h01 : (glyph_blank ? 8'h00 : (glyph_rdata_r & HMASK));
    hmask8   = is_pix ? 8'h01 : HMASK;
    ink_bits = ink_r ? col_bits : 8'h00;
    m16      = {8'b0, hmask8} << off;
    v16      = {8'b0, ink_bits} << off;
    col_ok   = (x_s >= 10'sd0) && (x_s < WIDTH_S);
    page_ok  = (page_s >= 9'sd0) && (page_s < PAGES_S);
    pvalid   = (page_s == (PAGES_S - 9'sd1)) ? LAST_MASK : 8'hFF;
    tgt_mask = (cmd.page_sel ? m16[15:8] : m16[7:0]) & pvalid;
    tgt_val  = cmd.page_sel ? v16[15:8] : v16[7:0];
    tgt_addr = FB_AW'(page_s[7:0]) * W_A + FB_AW'(x_s[8:0]);
  end

  // pending write back of the byte read this cycle
  logic             wr_ok_r;
  logic [FB_AW-1:0] wr_addr_r;
  logic [7:0]       wr_mask_r;
  logic [7:0]       wr_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ok_r <= 1'b0;
    end else begin
      wr_ok_r <= cmd.fb_rd && col_ok && page_ok;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= tgt_addr;
    wr_mask_r <= tgt_mask;
    wr_val_r  <= tgt_val;
  end

  // clear sweep counter, start clamped to the store
  logic [CLR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic signed [20:0] clr_start;

  always_comb begin
    clr_start    = $signed({{10{py_r[10]}}, py_r}) * W_S21 +
                   $signed({{12{px_r[8]}}, px_r});
    clr_addr_nxt = clr_addr_r;
    if (cmd.clr_init) begin
      if (clr_start < 21'sd0) begin
        clr_addr_nxt = '0;
      end else if (clr_start > FB_S21) begin
        clr_addr_nxt = FB_END;
      end else begin
        clr_addr_nxt = clr_start[CLR_W-1:0];
      end
    end else if (cmd.clr_wr) begin
      clr_addr_nxt = clr_addr_r + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // frame store, one write and one read port
  logic [7:0]       fb_mem [FB_BYTES];
  logic [7:0]       fb_rdata_r;
  logic             fb_we;
  logic [FB_AW-1:0] fb_waddr;
  logic [7:0]       fb_wdata;
  logic             fb_re;
  logic [FB_AW-1:0] fb_raddr;

  always_comb begin
    fb_we    = cmd.clr_wr || wr_ok_r;
    fb_waddr = cmd.clr_wr ? clr_addr_r[FB_AW-1:0] : wr_addr_r;
    fb_wdata = cmd.clr_wr ? 8'h00 : ((fb_rdata_r & ~wr_mask_r) | (wr_val_r & wr_mask_r));
    fb_re    = cmd.fb_rd || cmd.byte_rd;
    fb_raddr = cmd.fb_rd ? tgt_addr : FB_AW'(bidx_r);
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    if (fb_re) begin
      fb_rdata_r <= fb_mem[fb_raddr];
    end
  end

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= ({3'b000, bidx_r} < FB_SIZE) ? fb_rdata_r : 8'h00;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status
  always_comb begin
    sts.op       = op_r;
    sts.newline  = (code_r == NEWLINE);
    sts.col_last = (col_r == COL_LAST);
    sts.clr_done = (clr_addr_r == FB_END);
    sts.out_full = out_valid_r && !out_tready;
  end

  // checks
  `TTPF_ASSERT_IMP(a_wb_no_clear, wr_ok_r, !cmd.clr_wr, "draw write back during clear sweep")
  `TTPF_ASSERT_IMP(a_rd_wr_apart, cmd.fb_rd && col_ok && page_ok && wr_ok_r, tgt_addr != wr_addr_r, "frame read hits pending write back")
  `TTPF_ASSERT_IMP(a_out_free, cmd.out_load, !out_valid_r, "result loaded over an untaken beat")
  `TTPF_ASSERT_NXT(a_wrap_col, cmd.cursor_wrap && wrap_need, cur_col_r == 9'sd0, "cursor column not reset on wrap")
  `TTPF_ASSERT_IMP(a_clr_bound, 1'b1, clr_addr_r <= FB_END, "clear counter past end of store")

endmodule

// ===== verif/tb_text_to_page_framebuffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_to_page_framebuffer_top
// self-checking bench for the page frame buffer with character generator:
// glyph loads, text, pixel, clear and read beats go in with random gaps, the
// read port stalls at random, and every read byte is compared with a mirror
// of the frame store kept in the bench
// ----------------------------------------------------------------------------
module tb_text_to_page_framebuffer_top;
  import ttpf_pkg::*;

  // geometry and limits
  localparam int SCR_W        = SCREEN_WIDTH_DEF;
  localparam int SCR_H        = SCREEN_HEIGHT_DEF;
  localparam int GLY_W        = GLYPH_WIDTH_DEF;
  localparam int GLY_H        = GLYPH_HEIGHT_DEF;
  localparam int GLY_GAP      = GLYPH_GAP_DEF;
  localparam int GLY_N        = GLYPH_COUNT_DEF;
  localparam int FB_BYTES     = (SCR_H + 7) / 8 * SCR_W;
  localparam int ROW_CAP      = 1023;
  localparam int COL_CAP      = 255;
  localparam logic [6:0] CH_NEWLINE = 7'd10;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int N_ITEMS      = 1250;
  localparam int MAX_GAP      = 5;
  localparam int DRAIN_CYCLES = FB_BYTES + 64;
  localparam int DRAIN_EVERY  = 300;
  localparam int MAX_REPORTS  = 10;

  // one input beat, unpacked
  typedef struct {
    logic [2:0]         op;
    logic signed [8:0]  pos_x;
    logic signed [10:0] pos_y;
    logic [6:0]         char_code;
    logic [2:0]         glyph_col;
    logic [7:0]         glyph_bits;
    logic               ink_on;
    logic [9:0]         byte_index;
  } fb_cmd_t;

  // mirror of frame store, glyph store and text cursor, plus pending reads
  class page_fb_tracker;
    logic [7:0] frame [FB_BYTES];
    logic [7:0] glyphs [GLY_N*GLY_W];
    bit         written [GLY_N*GLY_W];
    int         cur_col;
    int         cur_row;
    logic [7:0] read_bytes_due [$];
    int unsigned fails;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      foreach (glyphs[i]) begin
        glyphs[i] = 8'h00;
        written[i] = 1'b0;
      end
      cur_col = 0;
      cur_row = 0;
      fails = 0;
    endfunction

    function bit glyph_complete(logic [6:0] code);
      for (int k = 0; k < GLY_W; k++)
        if (!written[code*GLY_W + k]) return 1'b0;
      return 1'b1;
    endfunction

    // single pixel, clipped at the screen edges
    function void plot(int x, int y, bit on);
      int a;
      if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) return;
      a = x + (y / 8) * SCR_W;
      frame[a][y % 8] = on;
    endfunction

    // one character at the cursor, wrapping first where needed
    function void place_char(logic [6:0] code, bit ink);
      bit nl;
      logic [7:0] bits;
      nl = (code == CH_NEWLINE);
      if (nl || cur_col >= SCR_W || (SCR_W - cur_col) < GLY_W) begin
        cur_col = 0;
        cur_row = cur_row + GLY_H + 1;
        if (cur_row > ROW_CAP) cur_row = ROW_CAP;
        if (nl) return;
      end
      for (int k = 0; k < GLY_W; k++) begin
        bits = glyphs[code*GLY_W + k];
        for (int r = 0; r < GLY_H; r++)
          plot(cur_col + k, cur_row + r, bits[r] && ink);
      end
      cur_col = cur_col + GLY_W + GLY_GAP;
      if (cur_col > COL_CAP) cur_col = COL_CAP;
    endfunction

    // apply one accepted beat; a read queues the byte it must return
    function void note_beat(fb_cmd_t c);
      int start;
      case (c.op)
        OP_LOAD_GLYPH: begin
          if (c.glyph_col < GLY_W) begin
            glyphs[c.char_code*GLY_W + c.glyph_col] = c.glyph_bits;
            written[c.char_code*GLY_W + c.glyph_col] = 1'b1;
          end
        end
        OP_START_TEXT: begin
          cur_col = int'(c.pos_x);
          cur_row = int'(c.pos_y);
        end
        OP_PUT_CHAR: place_char(c.char_code, c.ink_on);
        OP_SET_PIXEL: plot(int'(c.pos_x), int'(c.pos_y), c.ink_on);
        OP_CLEAR_FROM: begin
          start = int'(c.pos_x) + int'(c.pos_y) * SCR_W;
          if (start < 0) start = 0;
          if (start > FB_BYTES) start = FB_BYTES;
          for (int a = start; a < FB_BYTES; a++) frame[a] = 8'h00;
        end
        OP_READ_BYTE: read_bytes_due.push_back(frame[c.byte_index]);
        default: ;
      endcase
    endfunction

    function void report(string msg);
      fails++;
      if (fails <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    function void check_read_byte(logic [7:0] got);
      logic [7:0] want;
      if (read_bytes_due.size() == 0) begin
        report($sformatf("read beat %h with no read pending", got));
        return;
      end
      want = read_bytes_due.pop_front();
      if (got !== want)
        report($sformatf("read_data expected %h, got %h", want, got));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  page_fb_tracker fb_mirror = new();
  bit burst_mode = 1'b0;
  int stall_left = 0;
  int sent = 0;
  int hot_addr = 0;

  text_to_page_framebuffer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // read port: random stall after every beat, none in burst stretches
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      fb_mirror.check_read_byte(out_tdata);
      n = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      out_tready <= (n == 0);
      stall_left <= n;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // random filler for every field, kept inside the field ranges
  function automatic fb_cmd_t rand_cmd(logic [2:0] op);
    fb_cmd_t c;
    c.op         = op;
    c.pos_x      = 9'($urandom);
    c.pos_y      = 11'($urandom_range(0, 1279) - 256);
    c.char_code  = 7'($urandom);
    c.glyph_col  = 3'($urandom_range(0, GLY_W - 1));
    c.glyph_bits = 8'($urandom);
    c.ink_on     = 1'($urandom);
    c.byte_index = 10'($urandom);
    return c;
  endfunction

  // one beat on the input port after a random gap
  task automatic send_cmd(input fb_cmd_t c);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= {7'd0, c.byte_index, c.ink_on, c.glyph_bits, c.glyph_col,
                  c.char_code, c.pos_y, c.pos_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fb_mirror.note_beat(c);
    if (c.op != OP_SPARE_6 && c.op != OP_SPARE_7 &&
        !(c.op == OP_LOAD_GLYPH && c.glyph_col >= GLY_W)) sent++;
  endtask

  // hold the input idle until every read has come back
  task automatic wait_reads_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (fb_mirror.read_bytes_due.size() != 0);
  endtask

  task automatic do_load(input int code, input int col, input int bits);
    fb_cmd_t c;
    c = rand_cmd(OP_LOAD_GLYPH);
    c.char_code = 7'(code);
    c.glyph_col = 3'(col);
    c.glyph_bits = 8'(bits);
    send_cmd(c);
  endtask

  task automatic do_start(input int x, input int y);
    fb_cmd_t c;
    c = rand_cmd(OP_START_TEXT);
    c.pos_x = 9'(x);
    c.pos_y = 11'(y);
    send_cmd(c);
  endtask

  task automatic do_char(input logic [6:0] code, input bit ink);
    fb_cmd_t c;
    c = rand_cmd(OP_PUT_CHAR);
    c.char_code = code;
    c.ink_on = ink;
    send_cmd(c);
  endtask

  task automatic do_pixel(input int x, input int y, input bit ink);
    fb_cmd_t c;
    c = rand_cmd(OP_SET_PIXEL);
    c.pos_x = 9'(x);
    c.pos_y = 11'(y);
    c.ink_on = ink;
    send_cmd(c);
  endtask

  task automatic do_clear(input int x, input int y);
    fb_cmd_t c;
    c = rand_cmd(OP_CLEAR_FROM);
    c.pos_x = 9'(x);
    c.pos_y = 11'(y);
    send_cmd(c);
  endtask

  task automatic do_read(input int a);
    fb_cmd_t c;
    c = rand_cmd(OP_READ_BYTE);
    c.byte_index = 10'(a);
    send_cmd(c);
  endtask

  // a fully loaded glyph, so no unwritten glyph column is ever drawn
  function automatic logic [6:0] pick_glyph();
    logic [6:0] code;
    for (int t = 0; t < 16; t++) begin
      code = 7'($urandom_range(0, GLY_N - 1));
      if (code != CH_NEWLINE && fb_mirror.glyph_complete(code)) return code;
    end
    return 7'(GLY_N - 1);
  endfunction

  // stimulus
  initial begin
    int pick;
    int sel;
    int x;
    int y;
    int n;
    int code;
    bit ink;
    int next_drain;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: read after the clearing pass, then edge cases
    do_read(0);
    do_load(GLY_N - 1, 0, 8'hFF);
    do_load(GLY_N - 1, 1, 8'h80);
    do_load(GLY_N - 1, 2, 8'h55);
    do_load(GLY_N - 1, 3, 8'hAA);
    do_load(GLY_N - 1, 4, 8'h01);
    do_load(GLY_N - 1, 7, 8'hFF);        // column out of range, ignored
    do_start(SCR_W - GLY_W, 0);          // exactly fits at the right edge
    do_char(7'(GLY_N - 1), 1'b1);
    do_char(7'(GLY_N - 1), 1'b1);        // column past the edge, wraps
    do_char(CH_NEWLINE, 1'b1);
    do_start(SCR_W - GLY_W + 1, 1020);   // too little room, row saturates
    do_char(7'(GLY_N - 1), 1'b0);
    do_start(-256, -256);                // fully off screen
    do_char(7'(GLY_N - 1), 1'b1);
    do_start(60, 59);                    // clipped at the bottom
    do_char(7'(GLY_N - 1), 1'b1);
    do_pixel(SCR_W - 1, SCR_H - 1, 1'b1);
    do_pixel(SCR_W, 0, 1'b1);            // off screen
    do_pixel(-1, SCR_H, 1'b1);           // off screen
    do_pixel(SCR_W - GLY_W, 0, 1'b0);
    do_read(SCR_W - GLY_W);
    do_read(SCR_W - 1);
    do_read(FB_BYTES - 1);
    do_clear(0, 4);                      // upper half of the store
    do_read(FB_BYTES - 1);
    do_clear(-256, -256);                // clamps to the first byte
    do_clear(255, 1023);                 // clamps past the end
    do_read(SCR_W);
    begin
      fb_cmd_t c;
      c = rand_cmd(OP_SPARE_6);
      send_cmd(c);
      c = rand_cmd(OP_SPARE_7);
      send_cmd(c);
    end
    wait_reads_done();

    // random mix of glyph loads, text runs, pixels, clears and reads
    next_drain = DRAIN_EVERY;
    while (sent < N_ITEMS) begin
      if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // whole glyph, column by column
        code = $urandom_range(0, GLY_N - 1);
        for (int k = 0; k < GLY_W; k++) do_load(code, k, $urandom_range(0, 255));
      end else if (pick < 14) begin
        // stray column, may be out of range
        do_load($urandom_range(0, GLY_N - 1), $urandom_range(0, 7), $urandom_range(0, 255));
      end else if (pick < 22) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0: begin x = $urandom_range(SCR_W - 8, SCR_W - 1); y = $urandom_range(0, 56); end
          1: begin x = $urandom_range(SCR_W, 255); y = $urandom_range(0, 63); end
          2: begin x = -$urandom_range(1, 256); y = $urandom_range(0, 56); end
          3: begin x = $urandom_range(0, SCR_W - 1); y = $urandom_range(1000, 1023); end
          4: begin x = $urandom_range(0, SCR_W - 1); y = -$urandom_range(1, 256); end
          default: begin x = $urandom_range(0, SCR_W - GLY_W - 1); y = $urandom_range(0, 56); end
        endcase
        do_start(x, y);
      end else if (pick < 46) begin
        // text run with one ink, rarely flipped
        n = $urandom_range(1, 12);
        ink = ($urandom_range(0, 7) != 0);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 15) == 0) ink = !ink;
          if ($urandom_range(0, 9) == 0) do_char(CH_NEWLINE, ink);
          else do_char(pick_glyph(), ink);
        end
        x = fb_mirror.cur_col - 4;
        y = fb_mirror.cur_row;
        if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H) hot_addr = x + (y / 8) * SCR_W;
      end else if (pick < 60) begin
        if ($urandom_range(0, 4) != 0) begin
          x = $urandom_range(0, SCR_W - 1);
          y = $urandom_range(0, SCR_H - 1);
          hot_addr = x + (y / 8) * SCR_W;
        end else begin
          x = $urandom_range(0, 511) - 256;
          y = $urandom_range(0, 1279) - 256;
        end
        do_pixel(x, y, $urandom_range(0, 9) < 7);
      end else if (pick < 63) begin
        x = $urandom_range(0, 511) - 256;
        y = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 1279) - 256;
        do_clear(x, y);
      end else if (pick < 65) begin
        begin
          fb_cmd_t c;
          c = rand_cmd($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7);
          send_cmd(c);
        end
      end else begin
        // reads, half of them near what was drawn last
        if ($urandom_range(0, 1))
          do_read((hot_addr + $urandom_range(0, 2) + SCR_W * $urandom_range(0, 1)) % FB_BYTES);
        else
          do_read($urandom_range(0, FB_BYTES - 1));
      end
      if (sent >= next_drain) begin
        wait_reads_done();
        next_drain = next_drain + DRAIN_EVERY;
      end
    end

    // let every read come back and any clear finish
    in_tvalid <= 1'b0;
    while (fb_mirror.read_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fb_mirror.fails == 0 && fb_mirror.read_bytes_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, many times the slowest expected run
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ttpf_pkg.sv
rtl/ttpf_ctrl.sv
rtl/ttpf_dp.sv
rtl/text_to_page_framebuffer_top.sv
verif/tb_text_to_page_framebuffer_top.sv
